FILE: sv/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg: shared types, constants and microprogram for the PID motor drive
// Widths of the fixed-point datapath, register indexes, control word layout
// and the step table that the sequencer runs.
// ----------------------------------------------------------------------------
package pmd_pkg;

  // datapath widths
  localparam int ERR_W     = 17;  // reference - measured
  localparam int DIFF_W    = 18;  // error - last error
  localparam int INT_W     = 40;  // integral, Q23.16
  localparam int INT_SPLIT = 24;  // integral split for the two Ki products
  localparam int DERIV_W   = 34;  // (error delta) * rate
  localparam int MA_W      = 35;  // multiplier operand A, signed
  localparam int MB_W      = 17;  // multiplier operand B, signed (gain zero-extended)
  localparam int PROD_W    = 52;
  localparam int TD_W      = 46;  // clamped D term, Q.8
  localparam int ACC_W     = 64;  // term sum, Q.24
  localparam int FRAC_SH   = 24;
  localparam int MAG_W     = ACC_W - FRAC_SH;
  localparam int MAG_S_W   = 7;   // magnitude that can still fit below the clamp
  localparam int SCALE_W   = 25;
  localparam int STEP_W    = 4;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_GAIN_P   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GAIN_I   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GAIN_D   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_PERIOD   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RATE     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_OFFSET   = 3'd5;

  localparam logic [15:0] RST_GAIN_P = 16'd128;
  localparam logic [15:0] RST_GAIN_I = 16'd205;
  localparam logic [15:0] RST_GAIN_D = 16'd15;
  localparam logic [15:0] RST_PERIOD = 16'd655;
  localparam logic [15:0] RST_RATE   = 16'd100;
  localparam logic [7:0]  RST_OFFSET = 8'd25;

  // D term limit, 2^44 in Q.8
  localparam longint TD_LIM = 64'sd17592186044416;
  // |u| above this always clamps the speed
  localparam logic [MAG_W-1:0] MAG_LIM = 40'd100;
  // 255/100 in Q.16, rounded up; exact floor for |u| <= 100
  localparam logic [SCALE_W-1:0] SCALE_K = 25'd167117;
  localparam logic [7:0] SPEED_MAX = 8'd255;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] period;
    logic [15:0] rate;
    logic [7:0]  offset;
  } cfg_t;

  // operand A select
  localparam logic [2:0] MA_ERR    = 3'd0;
  localparam logic [2:0] MA_DIFF   = 3'd1;
  localparam logic [2:0] MA_DERIV  = 3'd2;
  localparam logic [2:0] MA_INT_LO = 3'd3;
  localparam logic [2:0] MA_INT_HI = 3'd4;

  // operand B select
  localparam logic [2:0] MB_PERIOD = 3'd0;
  localparam logic [2:0] MB_RATE   = 3'd1;
  localparam logic [2:0] MB_KP     = 3'd2;
  localparam logic [2:0] MB_KD     = 3'd3;
  localparam logic [2:0] MB_KI     = 3'd4;

  // accumulator ops
  localparam logic [2:0] ACC_HOLD   = 3'd0;
  localparam logic [2:0] ACC_LOAD_P = 3'd1;  // acc = prod << 16
  localparam logic [2:0] ACC_ADD_D  = 3'd2;  // acc += clamp(prod) << 16
  localparam logic [2:0] ACC_ADD_LO = 3'd3;  // acc += prod
  localparam logic [2:0] ACC_ADD_HI = 3'd4;  // acc += prod << 24

  // integral ops
  localparam logic [1:0] INT_HOLD     = 2'd0;
  localparam logic [1:0] INT_ADD_PROD = 2'd1;
  localparam logic [1:0] INT_WINDUP   = 2'd2;  // only when the speed clamps

  // jump conditions
  localparam logic [1:0] JC_NONE     = 2'd0;
  localparam logic [1:0] JC_NO_IN    = 2'd1;
  localparam logic [1:0] JC_OUT_BUSY = 2'd2;

  // step addresses
  localparam logic [STEP_W-1:0] ST_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] ST_INT_MUL = 4'd1;
  localparam logic [STEP_W-1:0] ST_INT_ACC = 4'd2;
  localparam logic [STEP_W-1:0] ST_P_MUL   = 4'd3;
  localparam logic [STEP_W-1:0] ST_D_MUL   = 4'd4;
  localparam logic [STEP_W-1:0] ST_LO_MUL  = 4'd5;
  localparam logic [STEP_W-1:0] ST_HI_MUL  = 4'd6;
  localparam logic [STEP_W-1:0] ST_HI_ADD  = 4'd7;
  localparam logic [STEP_W-1:0] ST_MAG     = 4'd8;
  localparam logic [STEP_W-1:0] ST_EMIT    = 4'd9;

  typedef struct packed {
    logic [1:0]        jc;
    logic [STEP_W-1:0] jt;
    logic              wrap;
    logic              take_in;
    logic [2:0]        ma;
    logic [2:0]        mb;
    logic [2:0]        acc_op;
    logic [1:0]        int_op;
    logic              deriv_ld;
    logic              last_ld;
    logic              mag_ld;
    logic              out_ld;
  } ctrl_t;

  // microprogram ROM
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    unique case (step)
      ST_IDLE: begin
        w.jc      = JC_NO_IN;
        w.jt      = ST_IDLE;
        w.take_in = 1'b1;
      end
      ST_INT_MUL: begin
        w.ma = MA_ERR;
        w.mb = MB_PERIOD;
      end
      ST_INT_ACC: begin
        w.int_op  = INT_ADD_PROD;
        w.ma      = MA_DIFF;
        w.mb      = MB_RATE;
        w.last_ld = 1'b1;
      end
      ST_P_MUL: begin
        w.deriv_ld = 1'b1;
        w.ma       = MA_ERR;
        w.mb       = MB_KP;
      end
      ST_D_MUL: begin
        w.acc_op = ACC_LOAD_P;
        w.ma     = MA_DERIV;
        w.mb     = MB_KD;
      end
      ST_LO_MUL: begin
        w.acc_op = ACC_ADD_D;
        w.ma     = MA_INT_LO;
        w.mb     = MB_KI;
      end
      ST_HI_MUL: begin
        w.acc_op = ACC_ADD_LO;
        w.ma     = MA_INT_HI;
        w.mb     = MB_KI;
      end
      ST_HI_ADD: begin
        w.acc_op = ACC_ADD_HI;
      end
      ST_MAG: begin
        w.mag_ld = 1'b1;
      end
      ST_EMIT: begin
        w.jc     = JC_OUT_BUSY;
        w.jt     = ST_EMIT;
        w.wrap   = 1'b1;
        w.out_ld = 1'b1;
        w.int_op = INT_WINDUP;
      end
      default: begin
        w.wrap = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/pid_motor_drive.sv
// ----------------------------------------------------------------------------
// pid_motor_drive: fixed-point PID position controller for a DC motor drive
// One item in (target and measured position), one drive command out
// (direction and speed byte), with integral anti-windup on speed clamp.
// ----------------------------------------------------------------------------
//
// Usage:
//   s_axis carries one item per control tick: target position in
//   tdata[15:0], measured position in tdata[31:16], both signed.
//   m_axis returns one item per input item: direction in tdata[0],
//   speed in tdata[8:1].
//   Gains, sample period/rate and drive offset are written through
//   cfg_we/cfg_addr/cfg_wdata while the block is idle.
// Timing:
//   A microcoded sequencer runs a ten-step program around one shared
//   35x17 multiplier, which does all six products in turn. The result is
//   registered in the output step; a new item is taken only after the
//   program wraps back to idle. Steps: the idle step that takes the item,
//   six multiply steps, the last add, magnitude and output.
// Reset:
//   rst clears the integral, last error and output valid, and loads the
//   default register values. No clearing pass is needed.
// Stall:
//   The output register holds a finished item; the next input item is
//   accepted and worked on meanwhile, and the program waits at its last
//   step only if the earlier item has still not been taken.
//
module pid_motor_drive
  import pmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input item
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // [15:0] target_pos, [31:16] measured_position
  // result item
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [0] direction, [8:1] speed, [15:9] zero
  // configuration writes
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t       cfg;
  ctrl_t      ctrl;
  logic       go;
  logic       out_busy;
  logic       out_load;
  logic       direction;
  logic [7:0] speed;

  // config register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p <= RST_GAIN_P;
      cfg.gain_i <= RST_GAIN_I;
      cfg.gain_d <= RST_GAIN_D;
      cfg.period <= RST_PERIOD;
      cfg.rate   <= RST_RATE;
      cfg.offset <= RST_OFFSET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GAIN_P: cfg.gain_p <= cfg_wdata;
        REG_GAIN_I: cfg.gain_i <= cfg_wdata;
        REG_GAIN_D: cfg.gain_d <= cfg_wdata;
        REG_PERIOD: cfg.period <= cfg_wdata;
        REG_RATE:   cfg.rate   <= cfg_wdata;
        REG_OFFSET: cfg.offset <= cfg_wdata[7:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // output register still holding an item nobody has taken
  assign out_busy = m_axis_tvalid && !m_axis_tready;

  pmd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .out_busy (out_busy),
    .ctrl     (ctrl),
    .go       (go)
  );

  assign s_axis_tready = ctrl.take_in;
  assign out_load      = go && ctrl.out_ld;

  pmd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .go        (go),
    .ref_pos   (s_axis_tdata[15:0]),
    .meas_pos  (s_axis_tdata[31:16]),
    .direction (direction),
    .speed     (speed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {7'b0, speed, direction};

  // the sequencer leaves its idle step right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready held after an item was accepted");

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("output register loaded while still occupied");

  // a new result only comes out of the final program step
  a_result_from_program: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output valid rose outside the program");

endmodule

FILE: sv/pmd_mul.sv
// ----------------------------------------------------------------------------
// pmd_mul: shared signed multiplier with registered product
// One 35 x 17 signed product per cycle, registered and available in the next cycle.
// ----------------------------------------------------------------------------
module pmd_mul
  import pmd_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MA_W-1:0]   a,
  input  logic signed [MB_W-1:0]   b,
  output logic signed [PROD_W-1:0] p
);

  logic signed [PROD_W-1:0] a_ext;
  logic signed [PROD_W-1:0] b_ext;

  assign a_ext = {{(PROD_W-MA_W){a[MA_W-1]}}, a};
  assign b_ext = {{(PROD_W-MB_W){b[MB_W-1]}}, b};

  always_ff @(posedge clk) begin
    p <= a_ext * b_ext;
  end

endmodule

FILE: sv/pmd_seq.sv
// ----------------------------------------------------------------------------
// pmd_seq: microprogram sequencer
// Step counter over the control ROM, with hold-in-place jumps while waiting
// for an input item or for the output register to drain.
// ----------------------------------------------------------------------------
module pmd_seq
  import pmd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_busy,
  output ctrl_t ctrl,
  output logic  go
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              jump;

  assign ctrl = ucode(step);

  always_comb begin
    case (ctrl.jc)
      JC_NO_IN:    jump = !in_valid;
      JC_OUT_BUSY: jump = out_busy;
      default:     jump = 1'b0;
    endcase
  end

  // a taken jump means the step waits; its actions are suppressed
  assign go = !jump;

  always_comb begin
    if (jump) begin
      step_next = ctrl.jt;
    end else if (ctrl.wrap) begin
      step_next = ST_IDLE;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: sv/pmd_dp.sv
// ----------------------------------------------------------------------------
// pmd_dp: PID datapath
// Error, integral, derivative and term accumulator around one shared
// multiplier; speed scaling, offset, clamp and anti-windup at the end.
// ----------------------------------------------------------------------------
module pmd_dp
  import pmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  ctrl_t              ctrl,
  input  logic               go,
  input  logic signed [15:0] ref_pos,
  input  logic signed [15:0] meas_pos,
  output logic               direction,
  output logic [7:0]         speed
);

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   last_err;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [INT_W-1:0]   integ;
  logic signed [INT_W:0]     int_add;
  logic signed [INT_W:0]     int_sum;
  logic signed [INT_W-1:0]   int_sat;
  logic                      int_upd;
  logic signed [DERIV_W-1:0] deriv;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]          p_ext;
  logic signed [TD_W-1:0]    td;
  logic [ACC_W-1:0]          acc;
  logic [ACC_W-1:0]          acc_next;
  logic [ACC_W-1:0]          acc_abs;
  logic [MAG_W-1:0]          mag_hi;
  logic                      mag_ovf;
  logic [MAG_S_W-1:0]        mag_s;
  logic                      dir_r;
  logic [SCALE_W-1:0]        scaled;
  logic [8:0]                speed_sum;
  logic                      clamp;

  assign diff = {err[ERR_W-1], err} - {last_err[ERR_W-1], last_err};

  // operand select
  always_comb begin
    case (ctrl.ma)
      MA_ERR:    mul_a = {{(MA_W-ERR_W){err[ERR_W-1]}}, err};
      MA_DIFF:   mul_a = {{(MA_W-DIFF_W){diff[DIFF_W-1]}}, diff};
      MA_DERIV:  mul_a = {{(MA_W-DERIV_W){deriv[DERIV_W-1]}}, deriv};
      MA_INT_LO: mul_a = {{(MA_W-INT_SPLIT){1'b0}}, integ[INT_SPLIT-1:0]};
      MA_INT_HI: mul_a = {{(MA_W-INT_W+INT_SPLIT){integ[INT_W-1]}},
                          integ[INT_W-1:INT_SPLIT]};
      default:   mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.mb)
      MB_PERIOD: mul_b = {1'b0, cfg.period};
      MB_RATE:   mul_b = {1'b0, cfg.rate};
      MB_KP:     mul_b = {1'b0, cfg.gain_p};
      MB_KD:     mul_b = {1'b0, cfg.gain_d};
      MB_KI:     mul_b = {1'b0, cfg.gain_i};
      default:   mul_b = '0;
    endcase
  end

  pmd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // integral: add err*period, or take err<<16 back out on clamp; saturate
  always_comb begin
    if (ctrl.int_op == INT_WINDUP) begin
      int_add = -{{(INT_W+1-ERR_W-16){err[ERR_W-1]}}, err, 16'b0};
    end else begin
      int_add = {{(INT_W+1-DERIV_W){prod[DERIV_W-1]}}, prod[DERIV_W-1:0]};
    end
    int_sum = {integ[INT_W-1], integ} + int_add;
    if (int_sum[INT_W] != int_sum[INT_W-1]) begin
      int_sat = {int_sum[INT_W], {(INT_W-1){!int_sum[INT_W]}}};
    end else begin
      int_sat = int_sum[INT_W-1:0];
    end
  end

  assign int_upd = go && ((ctrl.int_op == INT_ADD_PROD) ||
                          ((ctrl.int_op == INT_WINDUP) && clamp));

  // D term limit
  always_comb begin
    if (prod > TD_LIM) begin
      td = TD_W'(TD_LIM);
    end else if (prod < -TD_LIM) begin
      td = TD_W'(-TD_LIM);
    end else begin
      td = prod[TD_W-1:0];
    end
  end

  assign p_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD_P: acc_next = {p_ext[ACC_W-17:0], 16'b0};
      ACC_ADD_D:  acc_next = acc + {{(ACC_W-TD_W-16){td[TD_W-1]}}, td, 16'b0};
      ACC_ADD_LO: acc_next = acc + p_ext;
      ACC_ADD_HI: acc_next = acc + {p_ext[ACC_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
      default:    acc_next = acc;
    endcase
  end

  // |u| = floor(|sum| / 2^24), i.e. truncation toward zero
  assign acc_abs = acc[ACC_W-1] ? -acc : acc;
  assign mag_hi  = acc_abs[ACC_W-1:FRAC_SH];

  // speed = floor(|u|*255/100) + offset, only meaningful for |u| <= 100
  assign scaled    = {{(SCALE_W-MAG_S_W){1'b0}}, mag_s} * SCALE_K;
  assign speed_sum = {1'b0, scaled[23:16]} + {1'b0, cfg.offset};
  assign clamp     = mag_ovf || speed_sum[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      last_err <= '0;
    end else begin
      if (int_upd) begin
        integ <= int_sat;
      end
      if (go && ctrl.last_ld) begin
        last_err <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctrl.take_in) begin
      err <= {ref_pos[15], ref_pos} - {meas_pos[15], meas_pos};
    end
    if (go && ctrl.deriv_ld) begin
      deriv <= prod[DERIV_W-1:0];
    end
    if (go) begin
      acc <= acc_next;
    end
    if (go && ctrl.mag_ld) begin
      mag_ovf <= mag_hi > MAG_LIM;
      mag_s   <= mag_hi[MAG_S_W-1:0];
      dir_r   <= !acc[ACC_W-1] && (mag_hi != '0);
    end
    if (go && ctrl.out_ld) begin
      direction <= dir_r;
      speed     <= clamp ? SPEED_MAX : speed_sum[7:0];
    end
  end

endmodule

FILE: bench/pmd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pmd_checker: drive command scoreboard for the PID motor drive
// Watches the register port and both item streams, keeps its own PID state
// and compares each drive item against the command predicted for it.
// ----------------------------------------------------------------------------
module pmd_checker
  import pmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // [15:0] target_pos, [31:16] measured_position
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [15:0]       m_axis_tdata,   // [0] direction, [8:1] speed
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                outstanding
);

  localparam longint INTEG_MAX = 64'sd549755813887;     // 2^39 - 1
  localparam longint INTEG_MIN = -64'sd549755813888;    // -2^39
  localparam longint TERM_MAX  = 64'sd1152921504606846976; // 2^60, Q.24
  localparam longint DTERM_MAX = 64'sd17592186044416;   // 2^44, Q.8

  typedef struct packed {
    logic       dir;
    logic [7:0] speed;
  } drive_cmd_t;

  cfg_t       regs;
  longint     integral_acc;  // Q23.16
  longint     err_last;
  drive_cmd_t drive_cmds_due[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic longint sat(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // one control tick: updates integral / last error, returns the drive command
  function automatic drive_cmd_t pid_update(input logic signed [15:0] target,
                                            input logic signed [15:0] actual);
    longint     err;
    longint     delta;
    longint     tp;
    longint     ti;
    longint     td;
    longint     u;
    longint     mag;
    longint     spd;
    drive_cmd_t cmd;
    err = longint'(target) - longint'(actual);
    integral_acc = sat(integral_acc + err * longint'(regs.period), INTEG_MIN, INTEG_MAX);
    delta = (err - err_last) * longint'(regs.rate);
    err_last = err;
    tp = sat(err * longint'(regs.gain_p) * 65536, -TERM_MAX, TERM_MAX);
    ti = sat(integral_acc * longint'(regs.gain_i), -TERM_MAX, TERM_MAX);
    td = sat(delta * longint'(regs.gain_d), -DTERM_MAX, DTERM_MAX) * 65536;
    u = (tp + ti + td) / 64'sd16777216;  // truncates toward zero
    cmd.dir = (u > 0);
    mag = cmd.dir ? u : -u;
    spd = mag * 255 / 100 + longint'(regs.offset);
    if (spd > 255) begin
      // clamp, and back the whole error out of the integral
      spd = 255;
      integral_acc = sat(integral_acc - err * 65536, INTEG_MIN, INTEG_MAX);
    end
    cmd.speed = spd[7:0];
    return cmd;
  endfunction

  always @(posedge clk) begin : watch
    drive_cmd_t due;
    if (rst) begin
      regs         = '{gain_p: RST_GAIN_P, gain_i: RST_GAIN_I, gain_d: RST_GAIN_D,
                       period: RST_PERIOD, rate: RST_RATE, offset: RST_OFFSET};
      integral_acc = 0;
      err_last     = 0;
      drive_cmds_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_GAIN_P: regs.gain_p = cfg_wdata;
          REG_GAIN_I: regs.gain_i = cfg_wdata;
          REG_GAIN_D: regs.gain_d = cfg_wdata;
          REG_PERIOD: regs.period = cfg_wdata;
          REG_RATE:   regs.rate   = cfg_wdata;
          REG_OFFSET: regs.offset = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_cmds_due.size() == 0) begin
          fail_count++;
          $display("%0t: drive item %h with none expected", $time, m_axis_tdata);
        end else begin
          due = drive_cmds_due.pop_front();
          if (m_axis_tdata[0] !== due.dir) begin
            fail_count++;
            $display("%0t: direction expected %0d got %0d", $time, due.dir, m_axis_tdata[0]);
          end
          if (m_axis_tdata[8:1] !== due.speed) begin
            fail_count++;
            $display("%0t: speed expected %0d got %0d", $time, due.speed, m_axis_tdata[8:1]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        drive_cmds_due.push_back(pid_update(s_axis_tdata[15:0], s_axis_tdata[31:16]));
    end
    outstanding = drive_cmds_due.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the PID motor drive
// Runs directed and random position items through several register settings
// and idle patterns; pmd_checker predicts and compares every drive item.
// ----------------------------------------------------------------------------
module tb_top;
  import pmd_pkg::*;

  // slowest legal run is ~1500 items plus receiver stalls;
  // this allows many times that
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_STALL   = 300;  // receiver hold-off for the back-pressure test

  // shapes of random position sequences
  typedef enum {MIXED, FAR_POSITIVE, FAR_NEGATIVE, NEAR_TRACK} pattern_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;   // [15:0] target_pos, [31:16] measured_position
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // [0] direction, [8:1] speed, [15:9] zero
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = REG_GAIN_P;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  int   fail_count;
  int   outstanding;
  int   cycle_count = 0;
  int   send_idle_pct = 31;
  int   recv_idle_pct = 77;
  logic long_stall_req = 1'b0;

  // directed items, {measured, target}
  logic [31:0] directed_items [$] = '{
    {16'h0000, 16'h0000},  // zero error: speed is the bare offset
    {16'h8000, 16'h7FFF},  // largest positive error
    {16'h7FFF, 16'h8000},  // largest negative error
    {16'h7FFF, 16'h7FFF},
    {16'h8000, 16'h8000},
    {16'h0000, 16'h0001},
    {16'h0001, 16'h0000},
    {16'h0000, 16'h0028},  // steady error, integral builds
    {16'h0000, 16'h0028},
    {16'h0000, 16'h0028},
    {16'h0028, 16'h0000},  // error flips: derivative kick
    {16'hFFFF, 16'h0000},
    {16'h5555, 16'hAAAA},
    {16'hAAAA, 16'h5555},
    {16'h0000, 16'h8000},
    {16'h8000, 16'h0000},
    {16'h0000, 16'h0000}
  };

  always #2 clk = ~clk;

  pid_motor_drive dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  pmd_checker checker_i (.*);

  // offer one item, idling first at the current rate; valid stays high after
  // the handshake so back-to-back items never drop it
  task automatic push_item(input logic [15:0] target, input logic [15:0] actual);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {actual, target};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop offering, wait for every drive item, then let the pipe go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // back-to-back writes of all six registers; block must be idle
  task automatic load_settings(input logic [15:0] kp, input logic [15:0] ki,
                               input logic [15:0] kd, input logic [15:0] period,
                               input logic [15:0] rate, input logic [7:0] offset);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_GAIN_P;
    cfg_wdata <= kp;
    @(posedge clk);
    cfg_addr  <= REG_GAIN_I;
    cfg_wdata <= ki;
    @(posedge clk);
    cfg_addr  <= REG_GAIN_D;
    cfg_wdata <= kd;
    @(posedge clk);
    cfg_addr  <= REG_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_addr  <= REG_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_addr  <= REG_OFFSET;
    cfg_wdata <= {8'd0, offset};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random items:
  //   MIXED        - measured position chasing a set point, plus raw noise
  //   FAR_POSITIVE - near full-scale positive error, drives the integral up
  //   FAR_NEGATIVE - same, negative
  //   NEAR_TRACK   - error within a few dozen counts, stays below the clamp
  task automatic run_random(input int count, input pattern_t pattern);
    int tgt;
    int pos;
    int a;
    int b;
    tgt = int'($urandom_range(65535)) - 32768;
    pos = int'($urandom_range(65535)) - 32768;
    for (int i = 0; i < count; i++) begin
      a = int'($urandom_range(32767, 30000));
      b = int'($urandom_range(32768, 30000));
      case (pattern)
        FAR_POSITIVE: push_item(16'(a), 16'(-b));
        FAR_NEGATIVE: push_item(16'(-b), 16'(a));
        NEAR_TRACK: begin
          if ($urandom_range(31) == 0) tgt = int'($urandom_range(60000)) - 30000;
          push_item(16'(tgt), 16'(tgt + int'($urandom_range(120)) - 60));
        end
        default: begin
          if ($urandom_range(99) < 25) begin
            push_item(16'($urandom), 16'($urandom));
          end else begin
            // new set point now and then, encoder closes in with some jitter
            if ($urandom_range(19) == 0) tgt = int'($urandom_range(65535)) - 32768;
            pos = pos + (tgt - pos) / int'($urandom_range(6, 1))
                + int'($urandom_range(40)) - 20;
            if (pos > 32767) pos = 32767;
            else if (pos < -32768) pos = -32768;
            push_item(16'(tgt), 16'(pos));
          end
        end
      endcase
    end
  endtask

  // receiver: random idling, or one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver heavily; reset defaults first
    foreach (directed_items[k]) push_item(directed_items[k][15:0], directed_items[k][31:16]);
    run_random(150, MIXED);
    settle();
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_random(150, MIXED);
    settle();
    // unity P, no I, small D at rate 1: speed mostly below the clamp
    load_settings(16'd256, 16'd0, 16'd16, 16'd655, 16'd1, 8'd0);
    run_random(250, NEAR_TRACK);
    settle();

    // roles swapped
    send_idle_pct = 77;
    recv_idle_pct = 31;
    // zero gains never clamp, so the integral runs into its upper limit
    load_settings(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'd0);
    run_random(160, FAR_POSITIVE);
    settle();
    // full I gain at the top: anti-windup pushes past the limit again
    load_settings(16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd1, 8'd0);
    run_random(30, FAR_NEGATIVE);
    run_random(50, MIXED);
    settle();
    // walk the integral down into its lower limit
    load_settings(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'd0);
    run_random(300, FAR_NEGATIVE);
    settle();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // anti-windup saturating at the bottom
    load_settings(16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd1, 8'd0);
    run_random(20, FAR_POSITIVE);
    settle();
    // zero period leaves only anti-windup moving the integral, zero rate kills the derivative
    load_settings(16'($urandom_range(300, 1)), 16'd0, 16'($urandom_range(5000, 1)),
                  16'd0, 16'd0, 8'($urandom));
    run_random(120, MIXED);
    settle();
    load_settings(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 8'd0);
    run_random(40, MIXED);
    settle();
    // receiver holds off long enough for the block to back up its input
    long_stall_req = 1'b1;
    repeat (2) begin
      load_settings(16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                    8'($urandom));
      run_random(100, MIXED);
      settle();
    end

    if (fail_count == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/pmd_pkg.sv
sv/pmd_mul.sv
sv/pmd_seq.sv
sv/pmd_dp.sv
sv/pid_motor_drive.sv
bench/pmd_checker.sv
bench/tb_top.sv
